// ===== rtl/pltv_pkg.sv =====
package pltv_pkg;

	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QAW    = $clog2(QDEPTH);

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_PARSE = 2'd1,
		ST_NOBUF = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0] packed_byte;
		logic [7:0] packet_length;
	} in_item_t;

	typedef struct packed {
		logic [7:0] plain_byte;
		logic       is_status;
		status_t    status;
		logic [7:0] plain_length;
	} out_item_t;

	// Work for the back end: up to two plain bytes, then an optional status.
	typedef struct packed {
		logic [1:0] n_bytes;
		logic [7:0] b0;
		logic [7:0] b1;
		logic       has_status;
		status_t    status;
		logic [7:0] plen;
	} cmd_t;

	// Bits needed to hold r-1 (smallest n with 2^n >= r).
	function automatic logic [3:0] bits_for(input logic [7:0] r);
		logic [7:0] m;
		logic [3:0] n;
		m = r - 8'd1;
		n = 4'd0;
		if (r != 8'd0) begin
			for (int i = 0; i < 8; i++) begin
				if (m[i]) begin
					n = 4'(i + 1);
				end
			end
		end
		return n;
	endfunction

endpackage

// ===== rtl/pltv_front.sv =====
module pltv_front
	import pltv_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       plain_max_we,
	input  logic [7:0] plain_max_wdata,
	input  logic       accept,
	input  in_item_t   item,
	output logic       push,
	output cmd_t       cmd
);

	typedef enum logic [4:0] {
		PH_IDLE   = 5'b00001,
		PH_HEADER = 5'b00010,
		PH_ESC    = 5'b00100,
		PH_VALUE  = 5'b01000,
		PH_DROP   = 5'b10000
	} phase_t;

	phase_t     phase_q, phase_d;
	logic [7:0] plain_max_q;
	logic [7:0] bytes_left_q, bytes_left_d;
	logic [7:0] value_left_q, value_left_d;
	logic [7:0] held_length_q, held_length_d;
	logic [7:0] out_count_q, out_count_d;
	logic       first_entry_q, first_entry_d;

	logic [7:0] b;
	logic [7:0] r_h, oc_h, len_h, type_h, bl_h, oc2_h;
	logic       fe_h, esc_h, over_h, nobuf_h, do_hdr;
	logic [3:0] n_h, shift_h;
	logic [8:0] mask_h;
	logic [1:0] hdrn_h;

	assign b = item.packed_byte;

	// Header decode; from idle the packet starts fresh with this byte.
	always_comb begin
		if (phase_q == PH_IDLE) begin
			r_h  = item.packet_length;
			fe_h = 1'b1;
			oc_h = 8'd0;
		end else begin
			r_h  = bytes_left_q;
			fe_h = first_entry_q;
			oc_h = out_count_q;
		end
		n_h     = bits_for(r_h);
		shift_h = 4'd8 - n_h;
		mask_h  = (9'd1 << shift_h) - 9'd1;
		len_h   = b >> shift_h;
		type_h  = b & mask_h[7:0];
		esc_h   = (n_h != 4'd0) && ((9'(b) & mask_h) == mask_h);
		hdrn_h  = esc_h ? 2'd2 : 2'd1;
		bl_h    = r_h - 8'd1;
		oc2_h   = oc_h + 8'd2;
		over_h  = (9'(hdrn_h) + 9'(len_h)) > 9'(r_h);
		nobuf_h = (10'(oc_h) + 10'd2 + 10'(len_h)) > 10'(plain_max_q);
	end

	always_comb begin
		phase_d       = phase_q;
		bytes_left_d  = bytes_left_q;
		value_left_d  = value_left_q;
		held_length_d = held_length_q;
		out_count_d   = out_count_q;
		first_entry_d = first_entry_q;
		cmd           = '0;
		cmd.status    = ST_OK;
		do_hdr        = 1'b0;
		if (accept) begin
			unique case (phase_q)
				PH_HEADER: begin
					do_hdr = 1'b1;
				end
				PH_ESC: begin
					bytes_left_d = bytes_left_q - 8'd1;
					cmd.n_bytes  = 2'd2;
					cmd.b0       = held_length_q;
					cmd.b1       = b;
					out_count_d  = out_count_q + 8'd2;
					if (held_length_q == 8'd0) begin
						if (bytes_left_d == 8'd0) begin
							cmd.has_status = 1'b1;
							cmd.plen       = out_count_d;
							phase_d        = PH_IDLE;
						end else begin
							phase_d = PH_HEADER;
						end
					end else begin
						value_left_d = held_length_q;
						phase_d      = PH_VALUE;
					end
				end
				PH_VALUE: begin
					bytes_left_d = bytes_left_q - 8'd1;
					value_left_d = value_left_q - 8'd1;
					cmd.n_bytes  = 2'd1;
					cmd.b0       = b;
					out_count_d  = out_count_q + 8'd1;
					if (value_left_d == 8'd0) begin
						if (bytes_left_d == 8'd0) begin
							cmd.has_status = 1'b1;
							cmd.plen       = out_count_d;
							phase_d        = PH_IDLE;
						end else begin
							phase_d = PH_HEADER;
						end
					end
				end
				PH_DROP: begin
					bytes_left_d = bytes_left_q - 8'd1;
					if (bytes_left_d == 8'd0) begin
						phase_d = PH_IDLE;
					end
				end
				default: begin
					phase_d = PH_IDLE;
					if (item.packet_length == 8'd0) begin
						cmd.has_status = 1'b1;
					end else begin
						do_hdr = 1'b1;
					end
				end
			endcase

			if (do_hdr) begin
				bytes_left_d  = bl_h;
				out_count_d   = oc_h;
				first_entry_d = fe_h;
				if (over_h) begin
					// a failing first entry still reports ok, length zero
					cmd.has_status = 1'b1;
					cmd.status     = fe_h ? ST_OK : ST_PARSE;
					phase_d        = (bl_h != 8'd0) ? PH_DROP : PH_IDLE;
				end else begin
					first_entry_d = 1'b0;
					if (nobuf_h) begin
						cmd.has_status = 1'b1;
						cmd.status     = ST_NOBUF;
						phase_d        = (bl_h != 8'd0) ? PH_DROP : PH_IDLE;
					end else if (esc_h) begin
						held_length_d = len_h;
						phase_d       = PH_ESC;
					end else begin
						cmd.n_bytes = 2'd2;
						cmd.b0      = len_h;
						cmd.b1      = type_h;
						out_count_d = oc2_h;
						if (len_h == 8'd0) begin
							if (bl_h == 8'd0) begin
								cmd.has_status = 1'b1;
								cmd.plen       = oc2_h;
								phase_d        = PH_IDLE;
							end else begin
								phase_d = PH_HEADER;
							end
						end else begin
							value_left_d = len_h;
							phase_d      = PH_VALUE;
						end
					end
				end
			end
		end
	end

	assign push = accept && ((cmd.n_bytes != 2'd0) || cmd.has_status);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			plain_max_q   <= 8'd255;
			bytes_left_q  <= 8'd0;
			value_left_q  <= 8'd0;
			held_length_q <= 8'd0;
			out_count_q   <= 8'd0;
			first_entry_q <= 1'b1;
		end else begin
			phase_q       <= phase_d;
			bytes_left_q  <= bytes_left_d;
			value_left_q  <= value_left_d;
			held_length_q <= held_length_d;
			out_count_q   <= out_count_d;
			first_entry_q <= first_entry_d;
			if (plain_max_we) begin
				plain_max_q <= plain_max_wdata;
			end
		end
	end

endmodule

// ===== rtl/pltv_queue.sv =====
module pltv_queue
	import pltv_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wr_cmd,
	input  logic pop,
	output cmd_t rd_cmd,
	output logic full,
	output logic empty
);

	cmd_t             mem_q [QDEPTH];
	logic [QAW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QAW:0]     count_q;

	assign full   = (count_q == (QAW+1)'(QDEPTH));
	assign empty  = (count_q == '0);
	assign rd_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) !(pop && empty))
		else $error("queue pop while empty");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count did not follow push");

endmodule

// ===== rtl/pltv_back.sv =====
module pltv_back
	import pltv_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cmd_t      head,
	input  logic      empty,
	output logic      pop,
	output logic      plain_valid,
	input  logic      plain_ready,
	output out_item_t plain_item
);

	logic [1:0] idx_q;
	logic       out_valid_q;
	out_item_t  out_q, nxt;
	logic [1:0] total;
	logic       fire, last;

	assign total = head.n_bytes + 2'(head.has_status);
	assign fire  = !empty && (!out_valid_q || plain_ready);
	assign last  = (idx_q == total - 2'd1);
	assign pop   = fire && last;

	always_comb begin
		nxt = '0;
		nxt.status = ST_OK;
		if (idx_q < head.n_bytes) begin
			nxt.plain_byte = (idx_q == 2'd0) ? head.b0 : head.b1;
		end else begin
			nxt.is_status    = 1'b1;
			nxt.status       = head.status;
			nxt.plain_length = (head.status == ST_OK) ? head.plen : 8'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				out_valid_q <= 1'b1;
				idx_q       <= last ? 2'd0 : idx_q + 2'd1;
			end else if (plain_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign plain_valid = out_valid_q;
	assign plain_item  = out_q;

	a_idx_in_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (idx_q < total))
		else $error("item index past end of command");
	a_idx_clear_after_pop: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (idx_q == 2'd0))
		else $error("item index not cleared after pop");
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && nxt.is_status) |-> last)
		else $error("status item not last of its command");

endmodule

// ===== rtl/packed_ltv_decoder_unit.sv =====
// Each command from the parser is registered in the command queue, then its results pass
//   through the output register to plain_item.
// Throughput: one packed byte per cycle while the 4-entry command queue has room;
//   results leave at one per cycle while plain_ready is high; a command holds up to three results.
// The output register takes a new result in the same cycle the previous one leaves.
// Reset (arst_n low, asynchronous): parser idle, queue and output empty, plain_max = 255.
module packed_ltv_decoder_unit
	import pltv_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       plain_max_we,
	input  logic [7:0] plain_max_wdata,
	input  logic       packed_valid,
	output logic       packed_ready,
	input  in_item_t   packed_item,
	output logic       plain_valid,
	input  logic       plain_ready,
	output out_item_t  plain_item
);

	logic accept, push, pop, full, empty;
	cmd_t wr_cmd, head;

	assign packed_ready = !full;
	assign accept       = packed_valid && packed_ready;

	pltv_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.plain_max_we    (plain_max_we),
		.plain_max_wdata (plain_max_wdata),
		.accept          (accept),
		.item            (packed_item),
		.push            (push),
		.cmd             (wr_cmd)
	);

	pltv_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (wr_cmd),
		.pop    (pop),
		.rd_cmd (head),
		.full   (full),
		.empty  (empty)
	);

	pltv_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.empty       (empty),
		.pop         (pop),
		.plain_valid (plain_valid),
		.plain_ready (plain_ready),
		.plain_item  (plain_item)
	);

endmodule
